// File: design/scc_pkg.sv
// ----------------------------------------------------------------------------
// Scrolling text console package
// Geometry, character codes, command codes, shared types and row/address
// helpers for the console datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

	// Geometry of the text store
	localparam int LINES      = 8;
	localparam int LINE_WIDTH = 39;
	localparam int USABLE     = LINE_WIDTH - 1;
	localparam int CAP_RAW    = ((USABLE + 7) / 8) * 8;
	localparam int CURSOR_CAP = (CAP_RAW > 63) ? 63 : CAP_RAW;
	localparam int DEPTH      = LINES * LINE_WIDTH;

	// Widths
	localparam int ROW_W   = $clog2(LINES);
	localparam int RROW_W  = 3;
	localparam int COL_W   = 6;
	localparam int POS_W   = COL_W + 1;
	localparam int CHAR_W  = 8;
	localparam int ADDR_W  = $clog2(DEPTH);

	// Character codes
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// Tab stops every eight columns
	localparam logic [2:0] TAB_LAST = 3'h7;

	// Command codes
	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Store port request from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// One result word
	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic [COL_W-1:0]  cursor_column;
		logic              feed_pending;
		logic              scrolled;
	} result_t;

	// Add two ring row indexes modulo LINES
	function automatic logic [ROW_W-1:0] row_add(input logic [ROW_W-1:0] a,
		input logic [ROW_W-1:0] b);
		logic [ROW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (ROW_W+1)'(LINES))
			s = s - (ROW_W+1)'(LINES);
		return s[ROW_W-1:0];
	endfunction

	// Flat store address of one cell
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return ADDR_W'(row) * ADDR_W'(LINE_WIDTH) + ADDR_W'(col);
	endfunction

endpackage

`default_nettype wire

// File: design/scc_in_if.sv
// ----------------------------------------------------------------------------
// Console request channel
// Valid/ready channel carrying one command word to the console.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_in_if;
	logic                              valid;
	logic                              ready;
	logic                              command;
	logic [scc_pkg::CHAR_W-1:0]        char_code;
	logic [scc_pkg::RROW_W-1:0]        read_row;
	logic [scc_pkg::COL_W-1:0]         read_col;

	modport source(output valid, output command, output char_code, output read_row,
		output read_col, input ready);
	modport sink(input valid, input command, input char_code, input read_row,
		input read_col, output ready);
endinterface

`default_nettype wire

// File: design/scc_out_if.sv
// ----------------------------------------------------------------------------
// Console response channel
// Valid/ready channel carrying one result word from the console.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_out_if;
	logic                         valid;
	logic                         ready;
	logic [scc_pkg::CHAR_W-1:0]   cell_char;
	logic [scc_pkg::COL_W-1:0]    cursor_column;
	logic                         feed_pending;
	logic                         scrolled;

	modport source(output valid, output cell_char, output cursor_column,
		output feed_pending, output scrolled, input ready);
	modport sink(input valid, input cell_char, input cursor_column,
		input feed_pending, input scrolled, output ready);
endinterface

`default_nettype wire

// File: design/scc_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 312
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: design/scc_ctrl.sv
// ----------------------------------------------------------------------------
// Console sequencer
// Decodes one command word and steps it through scroll, cell writes and
// cell reads, using one column counter and incrementer for every cell write.
// Per-line fill counts stand in for clearing the store.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	scc_in_if.sink                              req,
	input  wire logic                           out_busy,
	output scc_pkg::ram_req_t                   ram_req,
	input  wire logic [scc_pkg::CHAR_W-1:0]     ram_rdata,
	output logic                                done,
	output scc_pkg::result_t                    result
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DECODE  = 3'd1;
	localparam logic [2:0] ST_WRITE   = 3'd2;
	localparam logic [2:0] ST_RD_DATA = 3'd3;
	localparam logic [2:0] ST_DONE    = 3'd4;

	logic [2:0]                     state_q;
	logic                           cmd_q;
	logic [scc_pkg::CHAR_W-1:0]     char_q;
	logic [scc_pkg::RROW_W-1:0]     rrow_q;
	logic [scc_pkg::COL_W-1:0]      rcol_q;
	logic [scc_pkg::ROW_W-1:0]      top_q;
	logic [scc_pkg::COL_W-1:0]      cursor_q;
	logic                           flag_q;
	logic                           scrolled_q;
	logic                           hit_q;
	logic [scc_pkg::CHAR_W-1:0]     cell_q;
	logic [scc_pkg::POS_W-1:0]      pos_q;
	logic [scc_pkg::COL_W-1:0]      fill_q [scc_pkg::LINES];

	logic [scc_pkg::ROW_W-1:0]      bottom;
	logic [scc_pkg::ROW_W-1:0]      phys;
	logic                           is_tab;
	logic                           is_blank;
	logic                           is_lf;
	logic                           is_skip;
	logic                           need_scroll;
	logic                           wr_ok;
	logic                           wr_last;
	logic [scc_pkg::POS_W-1:0]      pos_nxt;
	logic [scc_pkg::COL_W-1:0]      pos_sat;
	logic                           accept;

	assign accept   = req.valid && req.ready;
	// Hold off the sender while in reset
	assign req.ready = arst_n && (state_q == ST_IDLE);

	// Decode the latched character
	assign is_tab   = (char_q == scc_pkg::CH_TAB);
	assign is_blank = is_tab || (char_q == scc_pkg::CH_SPACE);
	assign is_lf    = (char_q == scc_pkg::CH_LF);
	assign is_skip  = (char_q == scc_pkg::CH_CR) || (char_q == scc_pkg::CH_NUL);

	// Scroll for a pending feed, or for a printing character on a full line
	always_comb begin
		need_scroll = flag_q;
		if (!is_lf && !is_skip && !is_blank &&
			cursor_q >= scc_pkg::COL_W'(scc_pkg::USABLE))
			need_scroll = 1'b1;
	end

	// Ring rows
	assign bottom = scc_pkg::row_add(top_q, scc_pkg::ROW_W'(scc_pkg::LINES - 1));
	assign phys   = scc_pkg::row_add(top_q, scc_pkg::ROW_W'(rrow_q));

	// Column unit: write check, tab stop check, increment and saturate
	assign wr_ok   = (pos_q < scc_pkg::POS_W'(scc_pkg::USABLE));
	assign wr_last = !is_tab || (pos_q[2:0] == scc_pkg::TAB_LAST);
	assign pos_nxt = pos_q + scc_pkg::POS_W'(1);
	assign pos_sat = (pos_nxt > scc_pkg::POS_W'(scc_pkg::CURSOR_CAP)) ?
		scc_pkg::COL_W'(scc_pkg::CURSOR_CAP) : pos_nxt[scc_pkg::COL_W-1:0];

	// Store port
	always_comb begin
		ram_req.we    = (state_q == ST_WRITE) && wr_ok;
		ram_req.waddr = scc_pkg::cell_addr(bottom, pos_q[scc_pkg::COL_W-1:0]);
		ram_req.wdata = is_blank ? scc_pkg::CH_SPACE : char_q;
		ram_req.raddr = scc_pkg::cell_addr(phys, rcol_q);
	end

	// Hold the command word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.command;
			char_q <= req.char_code;
			rrow_q <= req.read_row;
			rcol_q <= req.read_col;
		end
	end

	// Sequencer and console state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			top_q      <= '0;
			cursor_q   <= '0;
			flag_q     <= 1'b0;
			scrolled_q <= 1'b0;
			hit_q      <= 1'b0;
			cell_q     <= '0;
			pos_q      <= '0;
			for (int i = 0; i < scc_pkg::LINES; i++)
				fill_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scrolled_q <= 1'b0;
						cell_q     <= '0;
						state_q    <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (cmd_q == scc_pkg::CMD_READ) begin
						hit_q   <= (32'(rrow_q) < scc_pkg::LINES) && (rcol_q < fill_q[phys]);
						state_q <= ST_RD_DATA;
					end else if (is_skip) begin
						state_q <= ST_DONE;
					end else begin
						// drop the oldest line and home the cursor
						if (need_scroll) begin
							fill_q[top_q] <= '0;
							top_q         <= scc_pkg::row_add(top_q, scc_pkg::ROW_W'(1));
							cursor_q      <= '0;
							flag_q        <= 1'b0;
							scrolled_q    <= 1'b1;
						end
						pos_q <= need_scroll ? '0 : scc_pkg::POS_W'(cursor_q);
						if (is_lf) begin
							flag_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					if (wr_ok)
						fill_q[bottom] <= pos_nxt[scc_pkg::COL_W-1:0];
					if (wr_last) begin
						cursor_q <= pos_sat;
						state_q  <= ST_DONE;
					end else begin
						pos_q <= pos_nxt;
					end
				end
				ST_RD_DATA: begin
					cell_q  <= hit_q ? ram_rdata : '0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_busy)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hand the result to the output register
	assign done                 = (state_q == ST_DONE) && !out_busy;
	assign result.cell_char     = cell_q;
	assign result.cursor_column = cursor_q;
	assign result.feed_pending  = flag_q;
	assign result.scrolled      = scrolled_q;

endmodule

`default_nettype wire

// File: design/scrolling_text_console_top.sv
// ----------------------------------------------------------------------------
// Scrolling text console
// Eight-line text store with cursor, deferred line feed and cell readback.
// ----------------------------------------------------------------------------
// A printing character or a space steps from acceptance to a result in the
// output register through accept, decode with any scroll, one cell write and
// hand-off; a tab makes one write step on each column up to the next tab stop.
// A line feed, carriage return or zero byte writes nothing. A read steps
// through accept, decode, registered store read and hand-off. A result that
// waits in the output register holds the sequencer in its hand-off cycle.
// The tab's steps come from the single column counter that visits one cell
// per cycle on the store's only write port. Scrolling needs no state of its
// own: a per-line fill count marks which cells hold data, so no clearing
// sweep runs after reset or on a scroll. The block takes a new word as soon
// as the previous result sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_text_console_top (
	input  wire logic clk,
	input  wire logic arst_n,
	scc_in_if.sink    req,
	scc_out_if.source rsp
);

	scc_pkg::ram_req_t             ram_req;
	logic [scc_pkg::CHAR_W-1:0]    ram_rdata;
	logic                          done;
	scc_pkg::result_t              result;
	scc_pkg::result_t              rsp_q;
	logic                          rsp_valid_q;
	logic                          out_busy;

	assign out_busy = rsp_valid_q && !rsp.ready;

	scc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_busy  (out_busy),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.done      (done),
		.result    (result)
	);

	scc_ram #(
		.WIDTH (scc_pkg::CHAR_W),
		.DEPTH (scc_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// Output register: load a finished word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			rsp_q <= result;
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.cell_char     = rsp_q.cell_char;
	assign rsp.cursor_column = rsp_q.cursor_column;
	assign rsp.feed_pending  = rsp_q.feed_pending;
	assign rsp.scrolled      = rsp_q.scrolled;

	// A finished word never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp_valid_q && !rsp.ready))
		else $error("result loaded over a pending word");

	// One word in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while busy");

	// Cursor stays within its cap
	a_cursor_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.cursor_column <= scc_pkg::COL_W'(scc_pkg::CURSOR_CAP)))
		else $error("cursor beyond cap");

	// Store writes stay inside the store
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (ram_req.waddr < scc_pkg::ADDR_W'(scc_pkg::DEPTH)))
		else $error("store write out of range");

endmodule

`default_nettype wire
